>>> rtl/rdd_pkg.sv
// Shared types and constants for the resource deadlock detector.
// Holds the item kinds, datapath operation codes, configuration register
// indexes and the command/status structs between controller and datapath.
package rdd_pkg;

    // Configuration register widths and reset values.
    localparam int PCOUNT_W   = 5;
    localparam int RCOUNT_W   = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PCOUNT_W-1:0]  PCOUNT_RST = 5'd16;
    localparam logic [RCOUNT_W-1:0]  RCOUNT_RST = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_COUNT  = 2'd1;

    typedef enum logic [1:0] {
        KIND_REQ   = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_AVAIL = 2'd2,
        KIND_RUN   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE        = 3'd0,
        OP_LOAD_REQ    = 3'd1,
        OP_LOAD_ALLOC  = 3'd2,
        OP_LOAD_AVAIL  = 3'd3,
        OP_INIT        = 3'd4,
        OP_HOLD        = 3'd5,
        OP_FIT         = 3'd6,
        OP_ADD         = 3'd7
    } t_op;

    typedef struct packed {
        t_op  op;
        logic first;      // first resource column of a row pass
        logic last;       // last resource column of a row pass
        logic fin_clear;  // clear the finished mask at the start of a run
    } t_cmd;

    typedef struct packed {
        logic finished;   // finished bit of the addressed process
        logic fits;       // every request of the last checked row fits in work
    } t_status;

endpackage

>>> rtl/rdd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rdd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rdd_dpath.sv
// Datapath of the deadlock detector: request, allocation, available and work
// memories, the finished mask and the per-row accumulators.
// Depends on rdd_pkg and rdd_ram.
module rdd_dpath
    import rdd_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int AMOUNT_WIDTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [((MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1)-1:0] i_p_idx,
    input  logic [((MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1)-1:0] i_r_idx,
    input  logic [AMOUNT_WIDTH-1:0] i_amount,
    output t_status                 o_status
);

    localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int MAT_AW = PIDX_W + RIDX_W;
    localparam int MAT_DEPTH = 1 << MAT_AW;
    // Work must hold available plus every allocation without overflow.
    localparam int WORK_W = AMOUNT_WIDTH + $clog2(MAX_PROCESSES + 1);

    logic [MAT_AW-1:0]       mat_addr;
    logic [AMOUNT_WIDTH-1:0] req_rd;
    logic [AMOUNT_WIDTH-1:0] alloc_rd;
    logic [AMOUNT_WIDTH-1:0] avail_rd;
    logic [WORK_W-1:0]       work_rd;
    logic                    work_we;
    logic [WORK_W-1:0]       work_wdata;
    logic                    n_holds;
    logic                    n_fits;

    t_op                     r_op_d;
    logic                    r_first_d;
    logic                    r_last_d;
    logic [PIDX_W-1:0]       r_p_d;
    logic [RIDX_W-1:0]       r_r_d;
    logic                    r_holds;
    logic                    r_fits;
    logic [MAX_PROCESSES-1:0] r_finished;

    assign mat_addr = {i_p_idx, i_r_idx};

    rdd_ram #(.WIDTH(AMOUNT_WIDTH), .DEPTH(MAT_DEPTH)) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD_REQ),
        .i_waddr (mat_addr),
        .i_wdata (i_amount),
        .i_raddr (mat_addr),
        .o_rdata (req_rd)
    );

    rdd_ram #(.WIDTH(AMOUNT_WIDTH), .DEPTH(MAT_DEPTH)) u_alloc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD_ALLOC),
        .i_waddr (mat_addr),
        .i_wdata (i_amount),
        .i_raddr (mat_addr),
        .o_rdata (alloc_rd)
    );

    rdd_ram #(.WIDTH(AMOUNT_WIDTH), .DEPTH(MAX_RESOURCES)) u_avail_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == OP_LOAD_AVAIL),
        .i_waddr (i_r_idx),
        .i_wdata (i_amount),
        .i_raddr (i_r_idx),
        .o_rdata (avail_rd)
    );

    // The work row is read at the issued column and written back at the registered
    // column in the next cycle, so during a pass the write trails the read by one column.
    rdd_ram #(.WIDTH(WORK_W), .DEPTH(MAX_RESOURCES)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (work_we),
        .i_waddr (r_r_d),
        .i_wdata (work_wdata),
        .i_raddr (i_r_idx),
        .o_rdata (work_rd)
    );

    always_comb begin
        n_holds    = (r_first_d ? 1'b0 : r_holds) | (alloc_rd != '0);
        n_fits     = (r_first_d ? 1'b1 : r_fits) & (WORK_W'(req_rd) <= work_rd);
        work_we    = (r_op_d == OP_INIT) || (r_op_d == OP_ADD);
        work_wdata = (r_op_d == OP_INIT) ? WORK_W'(avail_rd)
                                         : work_rd + WORK_W'(alloc_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_d     <= OP_NONE;
            r_finished <= '0;
        end else begin
            r_op_d <= i_cmd.op;
            if (i_cmd.fin_clear) begin
                r_finished <= '0;
            end else if (r_op_d == OP_HOLD && r_last_d) begin
                r_finished[r_p_d] <= !n_holds;
            end else if (r_op_d == OP_ADD && r_last_d) begin
                r_finished[r_p_d] <= 1'b1;
            end
        end
        r_first_d <= i_cmd.first;
        r_last_d  <= i_cmd.last;
        r_p_d     <= i_p_idx;
        r_r_d     <= i_r_idx;
        if (r_op_d == OP_HOLD) begin
            r_holds <= n_holds;
        end
        if (r_op_d == OP_FIT) begin
            r_fits <= n_fits;
        end
    end

    assign o_status.finished = r_finished[i_p_idx];
    assign o_status.fits     = r_fits;

    a_add_marks_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op_d == OP_ADD && r_last_d) |=> r_finished[$past(r_p_d)])
        else $error("process not marked finished after its allocation was added");

    a_hold_sets_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op_d == OP_HOLD && r_last_d && !i_cmd.fin_clear)
        |=> r_finished[$past(r_p_d)] == !$past(n_holds))
        else $error("initial finished bit does not match the holding scan");

    a_clear_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_clear |=> (r_finished == '0))
        else $error("finished mask not cleared at run start");

endmodule

>>> rtl/rdd_ctrl.sv
// Controller of the deadlock detector: configuration registers, the run
// sequencer and the result register.
// Depends on rdd_pkg; drives rdd_dpath through t_cmd and reads t_status.
module rdd_ctrl
    import rdd_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_kind,
    input  logic [((MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1)-1:0] i_process_index,
    input  logic [((MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1)-1:0] i_resource_index,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_deadlock,
    output t_cmd                    o_cmd,
    output logic [((MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1)-1:0] o_p_idx,
    output logic [((MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1)-1:0] o_r_idx,
    input  t_status                 i_status
);

    localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCNT_W = $clog2(MAX_PROCESSES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_HOLD,
        S_SETTLE,
        S_SCAN,
        S_FIT,
        S_FIT_WAIT,
        S_DECIDE,
        S_ADD,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [PCOUNT_W-1:0] r_proc_count;
    logic [RCOUNT_W-1:0] r_res_count;
    logic [PCNT_W-1:0]   r_p, n_p;
    logic [RIDX_W-1:0]   r_r, n_r;
    logic                r_seen, n_seen;
    logic                r_out_vld, n_out_vld;
    logic                r_deadlock, n_deadlock;

    logic [PCNT_W-1:0]   np;
    logic [RIDX_W-1:0]   last_col;
    logic                in_acc;
    logic                p_ok;
    logic                r_ok;

    // Counts of zero act as one and counts above the maximum saturate.
    always_comb begin
        if (r_proc_count == '0) begin
            np = PCNT_W'(1);
        end else if (int'(r_proc_count) > MAX_PROCESSES) begin
            np = PCNT_W'(MAX_PROCESSES);
        end else begin
            np = PCNT_W'(r_proc_count);
        end
        if (r_res_count == '0) begin
            last_col = '0;
        end else if (int'(r_res_count) > MAX_RESOURCES) begin
            last_col = RIDX_W'(MAX_RESOURCES - 1);
        end else begin
            last_col = RIDX_W'(int'(r_res_count) - 1);
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign p_ok       = int'(i_process_index) < MAX_PROCESSES;
    assign r_ok       = int'(i_resource_index) < MAX_RESOURCES;

    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_r        = r_r;
        n_seen     = r_seen;
        n_deadlock = r_deadlock;
        n_out_vld  = r_out_vld && i_out_stall;

        o_cmd.op        = OP_NONE;
        o_cmd.first     = (r_r == '0);
        o_cmd.last      = (r_r == last_col);
        o_cmd.fin_clear = 1'b0;
        o_p_idx         = r_p[PIDX_W-1:0];
        o_r_idx         = r_r;

        case (r_state)
            S_IDLE: begin
                o_p_idx = i_process_index;
                o_r_idx = i_resource_index;
                if (in_acc) begin
                    case (t_kind'(i_kind))
                        KIND_REQ: begin
                            if (p_ok && r_ok) begin
                                o_cmd.op = OP_LOAD_REQ;
                            end
                        end
                        KIND_ALLOC: begin
                            if (p_ok && r_ok) begin
                                o_cmd.op = OP_LOAD_ALLOC;
                            end
                        end
                        KIND_AVAIL: begin
                            if (r_ok) begin
                                o_cmd.op = OP_LOAD_AVAIL;
                            end
                        end
                        KIND_RUN: begin
                            o_cmd.fin_clear = 1'b1;
                            n_r             = '0;
                            n_state         = S_INIT;
                        end
                        default: begin
                            o_cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                if (r_r == last_col) begin
                    n_r     = '0;
                    n_p     = '0;
                    n_state = S_HOLD;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_HOLD: begin
                o_cmd.op = OP_HOLD;
                if (r_r == last_col) begin
                    n_r = '0;
                    if (r_p == np - 1'b1) begin
                        n_state = S_SETTLE;
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_SETTLE: begin
                // Lets the last work and finished writes land, then rescans.
                n_p     = '0;
                n_seen  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_p == np) begin
                    n_state = S_DONE;
                end else if (i_status.finished) begin
                    n_p = r_p + 1'b1;
                end else begin
                    n_r     = '0;
                    n_state = S_FIT;
                end
            end
            S_FIT: begin
                o_cmd.op = OP_FIT;
                if (r_r == last_col) begin
                    n_state = S_FIT_WAIT;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_FIT_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.fits) begin
                    n_r     = '0;
                    n_state = S_ADD;
                end else begin
                    // An unfinished process was passed over in this sweep.
                    n_seen  = 1'b1;
                    n_p     = r_p + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_ADD: begin
                o_cmd.op = OP_ADD;
                if (r_r == last_col) begin
                    n_state = S_SETTLE;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_deadlock = r_seen;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_proc_count <= PCOUNT_RST;
            r_res_count  <= RCOUNT_RST;
            r_p          <= '0;
            r_r          <= '0;
            r_seen       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_p       <= n_p;
            r_r       <= n_r;
            r_seen    <= n_seen;
            if (i_cfg_we && i_cfg_index == CFG_PROC_COUNT) begin
                r_proc_count <= i_cfg_data[PCOUNT_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_RES_COUNT) begin
                r_res_count <= i_cfg_data[RCOUNT_W-1:0];
            end
        end
        r_deadlock <= n_deadlock;
    end

    assign o_out_valid = r_out_vld;
    assign o_deadlock  = r_deadlock;

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT || r_state == S_HOLD || r_state == S_FIT || r_state == S_ADD)
        |-> (r_r <= last_col))
        else $error("resource column beyond the active count");

    a_done_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) == S_SCAN) |-> ($past(r_p) == $past(np)))
        else $error("run finished before the sweep covered every process");

    a_fit_goes_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && i_status.fits) |=> (r_state == S_ADD && r_r == '0))
        else $error("fitting process was not released");

endmodule

>>> rtl/resource_deadlock_detector_core.sv
// Top level of the multi-instance resource deadlock detector.
// Depends on rdd_pkg, rdd_ctrl, rdd_dpath (which uses rdd_ram).
//
//  Channel  Dir  Handshake                  Payload
//  in       in   i_in_valid / o_in_stall    i_kind, i_process_index,
//                                           i_resource_index, i_amount
//  out      out  o_out_valid / i_out_stall  o_deadlock
//  cfg      in   i_cfg_we                   i_cfg_index, i_cfg_data
//
// Loads (kinds 0..2) each write one RAM entry when their indexes are in
// range. A run copies available into work, scans each process row for held
// resources, then sweeps processes: an unfinished one gets a fit check and,
// if it fits, a release that adds its allocation to work and restarts the
// sweep. The result posts when a sweep ends, later while the output register
// still holds an unaccepted result. Each matrix RAM reads one entry per cycle.
// Reset is synchronous and active low; no clearing pass is needed.
// A finished result waits in the output register while loads keep flowing.
module resource_deadlock_detector_core
    import rdd_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int AMOUNT_WIDTH  = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_kind,
    input  logic [((MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1)-1:0] i_process_index,
    input  logic [((MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1)-1:0] i_resource_index,
    input  logic [AMOUNT_WIDTH-1:0] i_amount,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_deadlock,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int PIDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    t_cmd              cmd;
    t_status           status;
    logic [PIDX_W-1:0] p_idx;
    logic [RIDX_W-1:0] r_idx;

    rdd_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_process_index  (i_process_index),
        .i_resource_index (i_resource_index),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_deadlock       (o_deadlock),
        .o_cmd            (cmd),
        .o_p_idx          (p_idx),
        .o_r_idx          (r_idx),
        .i_status         (status)
    );

    rdd_dpath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_WIDTH  (AMOUNT_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_p_idx  (p_idx),
        .i_r_idx  (r_idx),
        .i_amount (i_amount),
        .o_status (status)
    );

endmodule
